### rtl/core/srdi_pkg.sv
// Shared constants and types for the reading-to-distance interpolator.
package srdi_pkg;

    localparam int DEFAULT_TABLE_POINTS = 8;
    localparam int DEFAULT_READING_BITS = 10;

    localparam int HALF_BITS     = 40;
    localparam int BP_PER_HALF   = 4;
    localparam int DIST_BITS     = 8;
    localparam int DIST_REG_BITS = 64;
    localparam int FRAC_BITS     = 8;
    localparam int OUT_BITS      = 16;
    localparam int QUOT_BITS     = 16;
    localparam int STATUS_BITS   = 2;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_BP_FIRST = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BP_SECOND = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_DISTANCES = 2'd2;

    localparam logic [STATUS_BITS-1:0] STATUS_INTERP = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_NEAR   = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FAR    = 2'd2;

    // Fields that ride alongside the divider
    typedef struct packed {
        logic signed [DIST_BITS-1:0] base_dist;
        logic                        negative;
        logic [STATUS_BITS-1:0]      status;
    } side_t;

endpackage

### rtl/core/sensor_reading_to_distance_interp.sv
// Converts sensor readings to distance by piecewise linear lookup on a calibration curve.
// The data path has 21 register stages: 4 front, 16 divider and 1 output.
// Throughput: one item per cycle; a stalled output lets empty stages fill before
// s_tready drops.
// Reset clears all valid bits and the three calibration registers to zero.
module sensor_reading_to_distance_interp #(
    parameter int TABLE_POINTS = srdi_pkg::DEFAULT_TABLE_POINTS,
    parameter int READING_BITS = srdi_pkg::DEFAULT_READING_BITS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((READING_BITS+7)/8)*8-1:0]       s_tdata,    // sensor_reading
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [srdi_pkg::OUT_BITS-1:0]           m_tdata,    // distance_fixed
    output logic [srdi_pkg::STATUS_BITS-1:0]        m_tuser,    // range_status
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [srdi_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [srdi_pkg::DIST_REG_BITS-1:0]      cfg_data
);

    localparam int RB       = READING_BITS;
    localparam int DB       = srdi_pkg::DIST_BITS;
    localparam int QB       = srdi_pkg::QUOT_BITS;
    localparam int HB       = srdi_pkg::HALF_BITS;
    localparam int HALF_EXT = (srdi_pkg::BP_PER_HALF * RB > HB) ?
                              srdi_pkg::BP_PER_HALF * RB : HB;
    localparam int LAST     = TABLE_POINTS - 1;
    localparam int PROD_W   = RB + DB;
    localparam int SUM_W    = srdi_pkg::OUT_BITS + 2;

    // Calibration registers
    logic [HB-1:0]                  bp_first_reg;
    logic [HB-1:0]                  bp_second_reg;
    logic [srdi_pkg::DIST_REG_BITS-1:0] dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bp_first_reg  <= '0;
            bp_second_reg <= '0;
            dist_reg      <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                srdi_pkg::REG_BP_FIRST:  bp_first_reg  <= cfg_data[HB-1:0];
                srdi_pkg::REG_BP_SECOND: bp_second_reg <= cfg_data[HB-1:0];
                srdi_pkg::REG_DISTANCES: dist_reg      <= cfg_data;
                default:                 ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    logic [HALF_EXT-1:0] first_ext;
    logic [HALF_EXT-1:0] second_ext;
    logic [RB-1:0]       bp      [TABLE_POINTS];
    logic signed [DB-1:0] pt_dist [TABLE_POINTS];

    assign first_ext  = HALF_EXT'(bp_first_reg);
    assign second_ext = HALF_EXT'(bp_second_reg);

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_POINTS; gi++)
        begin : g_table
            if (gi < srdi_pkg::BP_PER_HALF)
            begin : g_lo
                assign bp[gi] = first_ext[gi*RB +: RB];
            end
            else
            begin : g_hi
                assign bp[gi] = second_ext[(gi-srdi_pkg::BP_PER_HALF)*RB +: RB];
            end
            assign pt_dist[gi] = dist_reg[gi*DB +: DB];
        end
    endgenerate

    // Stage enables, from the output back to the input
    logic en0, en1, en2, en3, en_out;
    logic div_in_ready;
    logic div_out_valid;
    logic v0_reg, v1_reg, v2_reg, v3_reg;

    assign en3      = !v3_reg || div_in_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign en0      = !v0_reg || en1;
    assign s_tready = en0;

    // Stage 0: capture reading
    logic [RB-1:0] r0_reg;

    // Stage 1: compare against breakpoints, pick the segment or clamp
    logic [RB-1:0]                    r1_reg;
    logic [RB-1:0]                    b0_1_reg, b1_1_reg;
    logic signed [DB-1:0]             d0_1_reg, d1_1_reg;
    logic [srdi_pkg::STATUS_BITS-1:0] st1_reg;

    logic [RB-1:0]                    b0_next, b1_next;
    logic signed [DB-1:0]             d0_next, d1_next;
    logic [srdi_pkg::STATUS_BITS-1:0] st1_next;

    always_comb
    begin
        b0_next  = bp[0];
        b1_next  = bp[1];
        d0_next  = pt_dist[0];
        d1_next  = pt_dist[1];
        st1_next = srdi_pkg::STATUS_INTERP;
        // Lowest-index matching breakpoint wins: scan from the top down
        for (int i = LAST; i >= 1; i--)
        begin
            if (r0_reg >= bp[i])
            begin
                b0_next = bp[i-1];
                b1_next = bp[i];
                d0_next = pt_dist[i-1];
                d1_next = pt_dist[i];
            end
        end
        if (r0_reg < bp[LAST])
        begin
            st1_next = srdi_pkg::STATUS_FAR;
            d0_next  = pt_dist[LAST];
        end
        else if (r0_reg >= bp[0])
        begin
            st1_next = srdi_pkg::STATUS_NEAR;
            d0_next  = pt_dist[0];
        end
    end

    // Stage 2: offsets, span and distance step magnitude
    logic [RB-1:0]   t2_reg;
    logic [RB-1:0]   den2_reg;
    logic [DB-1:0]   dmag2_reg;
    srdi_pkg::side_t side2_reg;

    logic signed [DB:0] dd;
    logic [DB:0]        dd_neg;
    logic [RB-1:0]      t2_next, den2_next;
    logic [DB-1:0]      dmag2_next;
    srdi_pkg::side_t    side2_next;

    always_comb
    begin
        dd     = {d1_1_reg[DB-1], d1_1_reg} - {d0_1_reg[DB-1], d0_1_reg};
        dd_neg = -dd;
        side2_next.base_dist = d0_1_reg;
        side2_next.status    = st1_reg;
        if (st1_reg == srdi_pkg::STATUS_INTERP)
        begin
            t2_next             = b0_1_reg - r1_reg;
            den2_next           = b0_1_reg - b1_1_reg;
            side2_next.negative = dd[DB];
            dmag2_next          = dd[DB] ? dd_neg[DB-1:0] : dd[DB-1:0];
        end
        else
        begin
            // Clamped: zero step over a unit span gives a zero quotient
            t2_next             = '0;
            den2_next           = RB'(1);
            side2_next.negative = 1'b0;
            dmag2_next          = '0;
        end
    end

    // Stage 3: product of offset and step magnitude
    logic [PROD_W-1:0] prod3_reg;
    logic [RB-1:0]     den3_reg;
    srdi_pkg::side_t   side3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en0)
            begin
                v0_reg <= s_tvalid;
            end
            if (en1)
            begin
                v1_reg <= v0_reg;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            r0_reg <= s_tdata[RB-1:0];
        end
        if (en1)
        begin
            r1_reg   <= r0_reg;
            b0_1_reg <= b0_next;
            b1_1_reg <= b1_next;
            d0_1_reg <= d0_next;
            d1_1_reg <= d1_next;
            st1_reg  <= st1_next;
        end
        if (en2)
        begin
            t2_reg    <= t2_next;
            den2_reg  <= den2_next;
            dmag2_reg <= dmag2_next;
            side2_reg <= side2_next;
        end
        if (en3)
        begin
            prod3_reg <= PROD_W'(t2_reg) * PROD_W'(dmag2_reg);
            den3_reg  <= den2_reg;
            side3_reg <= side2_reg;
        end
    end

    // Dividend is the product scaled by 256; its top bits already lie below the span
    logic [QB-1:0]   div_quot;
    srdi_pkg::side_t div_side;
    logic [QB-1:0]   low_bits;

    assign low_bits = {prod3_reg[DB-1:0], {srdi_pkg::FRAC_BITS{1'b0}}};

    srdi_div_pipe #(
        .DEN_BITS  (RB),
        .QUOT_BITS (QB)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .in_ready  (div_in_ready),
        .in_rem    (prod3_reg[PROD_W-1:DB]),
        .in_low    (low_bits),
        .in_den    (den3_reg),
        .in_side   (side3_reg),
        .out_valid (div_out_valid),
        .out_ready (en_out),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    // Output register: base distance plus or minus the quotient
    logic                             out_valid_reg;
    logic [srdi_pkg::OUT_BITS-1:0]    out_dist_reg;
    logic [srdi_pkg::STATUS_BITS-1:0] out_status_reg;
    logic [SUM_W-1:0]                 base_ext;
    logic [SUM_W-1:0]                 quot_ext;
    logic [SUM_W-1:0]                 sum_next;

    assign en_out   = !out_valid_reg || m_tready;
    assign base_ext = {{2{div_side.base_dist[DB-1]}}, div_side.base_dist,
                       {srdi_pkg::FRAC_BITS{1'b0}}};
    assign quot_ext = SUM_W'(div_quot);
    assign sum_next = div_side.negative ? (base_ext - quot_ext) : (base_ext + quot_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en_out)
        begin
            out_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            out_dist_reg   <= sum_next[srdi_pkg::OUT_BITS-1:0];
            out_status_reg <= div_side.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_dist_reg;
    assign m_tuser  = out_status_reg;

endmodule

### rtl/core/srdi_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with elastic stalls.
module srdi_div_pipe #(
    parameter int DEN_BITS  = srdi_pkg::DEFAULT_READING_BITS,
    parameter int QUOT_BITS = srdi_pkg::QUOT_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [DEN_BITS-1:0]  in_rem,
    input  logic [QUOT_BITS-1:0] in_low,
    input  logic [DEN_BITS-1:0]  in_den,
    input  srdi_pkg::side_t      in_side,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [QUOT_BITS-1:0] out_quot,
    output srdi_pkg::side_t      out_side
);

    logic [QUOT_BITS-1:0] valid_reg;
    logic [DEN_BITS-1:0]  rem_reg  [QUOT_BITS];
    logic [QUOT_BITS-1:0] quot_reg [QUOT_BITS];
    logic [DEN_BITS-1:0]  den_reg  [QUOT_BITS];
    srdi_pkg::side_t      side_reg [QUOT_BITS];

    logic [DEN_BITS-1:0]  rem_next  [QUOT_BITS];
    logic [QUOT_BITS-1:0] quot_next [QUOT_BITS];
    logic [DEN_BITS-1:0]  den_src   [QUOT_BITS];
    srdi_pkg::side_t      side_src  [QUOT_BITS];
    logic [QUOT_BITS-1:0] valid_src;
    logic [QUOT_BITS:0]   en;

    assign en[QUOT_BITS] = out_ready;

    genvar k;
    generate
        for (k = 0; k < QUOT_BITS; k++)
        begin : g_stage
            logic [DEN_BITS-1:0]  rem_prev;
            logic [QUOT_BITS-1:0] quot_prev;
            logic [DEN_BITS:0]    shifted;
            logic [DEN_BITS:0]    diff;
            logic                 take;

            if (k == 0)
            begin : g_first
                assign rem_prev     = in_rem;
                assign quot_prev    = in_low;
                assign den_src[k]   = in_den;
                assign side_src[k]  = in_side;
                assign valid_src[k] = in_valid;
            end
            else
            begin : g_rest
                assign rem_prev     = rem_reg[k-1];
                assign quot_prev    = quot_reg[k-1];
                assign den_src[k]   = den_reg[k-1];
                assign side_src[k]  = side_reg[k-1];
                assign valid_src[k] = valid_reg[k-1];
            end

            // Shift in the next dividend bit, subtract when the divisor fits
            assign shifted      = {rem_prev, quot_prev[QUOT_BITS-1]};
            assign diff         = shifted - {1'b0, den_src[k]};
            assign take         = (shifted >= {1'b0, den_src[k]});
            assign rem_next[k]  = take ? diff[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
            assign quot_next[k] = {quot_prev[QUOT_BITS-2:0], take};
            assign en[k]        = !valid_reg[k] || en[k+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < QUOT_BITS; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_src[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUOT_BITS; i++)
        begin
            if (en[i])
            begin
                rem_reg[i]  <= rem_next[i];
                quot_reg[i] <= quot_next[i];
                den_reg[i]  <= den_src[i];
                side_reg[i] <= side_src[i];
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[QUOT_BITS-1];
    assign out_quot  = quot_reg[QUOT_BITS-1];
    assign out_side  = side_reg[QUOT_BITS-1];

endmodule

### tb/sv/tb_top.sv
// Self-checking bench for the sensor reading to distance interpolator.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS        = srdi_pkg::DEFAULT_TABLE_POINTS;
    localparam int RBITS       = srdi_pkg::DEFAULT_READING_BITS;
    localparam int TDATA_BITS  = ((RBITS + 7) / 8) * 8;
    localparam int DUT_LATENCY = 21;
    localparam int LONG_HOLD   = 80;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_ITEMS = 200;
    localparam logic [srdi_pkg::CFG_IDX_BITS-1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [srdi_pkg::OUT_BITS-1:0]    distance;
        logic [srdi_pkg::STATUS_BITS-1:0] status;
    } reading_result_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 s_tvalid = 1'b0;
    logic                                 s_tready;
    logic [TDATA_BITS-1:0]                s_tdata = '0;
    logic                                 m_tvalid;
    logic                                 m_tready = 1'b0;
    logic [srdi_pkg::OUT_BITS-1:0]        m_tdata;
    logic [srdi_pkg::STATUS_BITS-1:0]     m_tuser;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [srdi_pkg::CFG_IDX_BITS-1:0]    cfg_index = '0;
    logic [srdi_pkg::DIST_REG_BITS-1:0]   cfg_data = '0;

    // Calibration as seen by the block, updated on each config transfer
    logic [srdi_pkg::HALF_BITS-1:0]       bp_first_cal = '0;
    logic [srdi_pkg::HALF_BITS-1:0]       bp_second_cal = '0;
    logic [srdi_pkg::DIST_REG_BITS-1:0]   dist_cal = '0;

    // Table under construction by the stimulus
    logic [RBITS-1:0]                     bp_set [NPTS];
    logic [srdi_pkg::DIST_BITS-1:0]       dist_set [NPTS];

    logic [RBITS-1:0]         readings_to_send [$];
    reading_result_t          distances_in_flight [$];

    logic in_fire = 1'b0;
    logic cfg_fire = 1'b0;
    int   quiet_cycles = 0;
    int   send_idle_pct = 19;
    int   recv_idle_pct = 60;
    int   long_stalls_asked = 0;
    int   long_stalls_served = 0;
    int   hold_left = 0;
    int   readings_sent = 0;
    int   results_checked = 0;
    int   near_count = 0;
    int   far_count = 0;
    int   interp_count = 0;
    int   tables_loaded = 0;
    int   mismatches = 0;

    sensor_reading_to_distance_interp u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint breakpoint_at(input int i);
        logic [srdi_pkg::HALF_BITS-1:0] half;
        half = (i < srdi_pkg::BP_PER_HALF) ? bp_first_cal : bp_second_cal;
        return longint'(half[(i % srdi_pkg::BP_PER_HALF) * RBITS +: RBITS]);
    endfunction

    function automatic longint distance_at(input int i);
        logic signed [srdi_pkg::DIST_BITS-1:0] d;
        d = dist_cal[i * srdi_pkg::DIST_BITS +: srdi_pkg::DIST_BITS];
        return longint'(d);
    endfunction

    function automatic reading_result_t convert_reading(input logic [RBITS-1:0] reading);
        longint          r;
        longint          b0;
        longint          den;
        longint          d0;
        longint          num;
        longint          val;
        reading_result_t res;
        r = longint'(reading);
        val = 0;
        res.status = srdi_pkg::STATUS_INTERP;
        // far clamp takes priority when a misordered table makes both apply
        if (r < breakpoint_at(NPTS - 1))
        begin
            val = distance_at(NPTS - 1) * 256;
            res.status = srdi_pkg::STATUS_FAR;
        end
        else if (r >= breakpoint_at(0))
        begin
            val = distance_at(0) * 256;
            res.status = srdi_pkg::STATUS_NEAR;
        end
        else
        begin
            for (int x = 1; x < NPTS; x++)
            begin
                if (r >= breakpoint_at(x))
                begin
                    b0 = breakpoint_at(x - 1);
                    den = breakpoint_at(x) - b0;
                    d0 = distance_at(x - 1);
                    num = (r - b0) * (distance_at(x) - d0) * 256;
                    val = (den != 0) ? d0 * 256 + num / den : d0 * 256;
                    break;
                end
            end
        end
        res.distance = val[srdi_pkg::OUT_BITS-1:0];
        return res;
    endfunction

    // Sampling side: all handshakes are observed here at the rising edge
    always @(posedge clk)
    begin : monitor
        reading_result_t want;
        in_fire <= s_tvalid && s_tready;
        cfg_fire <= cfg_valid && cfg_ready;
        quiet_cycles <= ((s_tvalid && s_tready) || (m_tvalid && m_tready)
                         || (cfg_valid && cfg_ready)) ? 0 : quiet_cycles + 1;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                srdi_pkg::REG_BP_FIRST:  bp_first_cal = cfg_data[srdi_pkg::HALF_BITS-1:0];
                srdi_pkg::REG_BP_SECOND: bp_second_cal = cfg_data[srdi_pkg::HALF_BITS-1:0];
                srdi_pkg::REG_DISTANCES: dist_cal = cfg_data;
                default: ;
            endcase
        end
        if (s_tvalid && s_tready)
        begin
            distances_in_flight.push_back(convert_reading(s_tdata[RBITS-1:0]));
            readings_sent++;
        end
        if (m_tvalid && m_tready)
        begin
            if (distances_in_flight.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result distance %h status %0d", $time,
                         m_tdata, m_tuser);
            end
            else
            begin
                want = distances_in_flight.pop_front();
                results_checked++;
                case (want.status)
                    srdi_pkg::STATUS_NEAR: near_count++;
                    srdi_pkg::STATUS_FAR:  far_count++;
                    default:               interp_count++;
                endcase
                if (m_tdata !== want.distance)
                begin
                    mismatches++;
                    $display("%0t: distance expected %h actual %h", $time, want.distance,
                             m_tdata);
                end
                if (m_tuser !== want.status)
                begin
                    mismatches++;
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             m_tuser);
                end
            end
        end
    end

    // Reading source: hold each transfer until accepted, then advance
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_fire))
        begin
            if (readings_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= {{(TDATA_BITS - RBITS){1'b0}}, readings_to_send.pop_front()};
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result sink with random stalls and an occasional long hold
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (long_stalls_served != long_stalls_asked)
        begin
            long_stalls_served <= long_stalls_asked;
            hold_left <= LONG_HOLD;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(negedge clk);
        $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    task automatic write_reg(input logic [srdi_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [srdi_pkg::DIST_REG_BITS-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(negedge clk);
        while (!cfg_fire);
        cfg_valid <= 1'b0;
    endtask

    // Wait for every result, then let the pipeline empty out
    task automatic settle;
        while (readings_to_send.size() != 0 || s_tvalid || distances_in_flight.size() != 0)
            @(negedge clk);
        repeat (DUT_LATENCY + 4) @(negedge clk);
    endtask

    task automatic load_table;
        logic [srdi_pkg::DIST_REG_BITS-1:0] first;
        logic [srdi_pkg::DIST_REG_BITS-1:0] second;
        logic [srdi_pkg::DIST_REG_BITS-1:0] dists;
        // junk above bit 39 must be dropped by the block
        first = {$urandom, $urandom};
        second = {$urandom, $urandom};
        for (int i = 0; i < srdi_pkg::BP_PER_HALF; i++)
        begin
            first[i * RBITS +: RBITS] = bp_set[i];
            second[i * RBITS +: RBITS] = bp_set[i + srdi_pkg::BP_PER_HALF];
        end
        for (int i = 0; i < NPTS; i++)
            dists[i * srdi_pkg::DIST_BITS +: srdi_pkg::DIST_BITS] = dist_set[i];
        write_reg(srdi_pkg::REG_BP_FIRST, first);
        write_reg(srdi_pkg::REG_BP_SECOND, second);
        write_reg(srdi_pkg::REG_DISTANCES, dists);
        tables_loaded++;
    endtask

    task automatic make_table(input bit descending);
        logic [RBITS-1:0] tmp;
        for (int i = 0; i < NPTS; i++)
        begin
            bp_set[i] = RBITS'($urandom_range((1 << RBITS) - 1));
            dist_set[i] = srdi_pkg::DIST_BITS'($urandom_range(255));
        end
        if (descending)
        begin
            for (int i = 1; i < NPTS; i++)
            begin
                for (int j = i; j > 0 && bp_set[j] > bp_set[j - 1]; j--)
                begin
                    tmp = bp_set[j];
                    bp_set[j] = bp_set[j - 1];
                    bp_set[j - 1] = tmp;
                end
            end
        end
    endtask

    // Favor readings that land on or next to a breakpoint
    task automatic queue_readings(input int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(3) == 0)
            begin
                r = int'(bp_set[$urandom_range(NPTS - 1)]) + int'($urandom_range(4)) - 2;
                if (r < 0)
                    r = 0;
                if (r > (1 << RBITS) - 1)
                    r = (1 << RBITS) - 1;
            end
            else
            begin
                r = int'($urandom_range((1 << RBITS) - 1));
            end
            readings_to_send.push_back(r[RBITS-1:0]);
        end
    endtask

    initial
    begin : stimulus
        int mark;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset table: every reading clamps near at zero
        readings_to_send.push_back(10'd0);
        readings_to_send.push_back(10'd1023);
        settle();
        // An unmapped index must leave the table alone
        write_reg(REG_UNMAPPED, '1);
        readings_to_send.push_back(10'd512);
        settle();

        // Full-span table with both distance extremes
        bp_set = '{10'd1023, 10'd900, 10'd700, 10'd500, 10'd300, 10'd200, 10'd100, 10'd1};
        dist_set = '{8'h80, 8'h7f, 8'hff, 8'h00, 8'd100, 8'h9c, 8'd50, 8'h7f};
        load_table();
        foreach (bp_set[i])
            readings_to_send.push_back(bp_set[i]);
        readings_to_send.push_back(10'd1022);
        readings_to_send.push_back(10'd0);
        readings_to_send.push_back(10'd499);
        readings_to_send.push_back(10'd850);
        readings_to_send.push_back(10'd150);
        settle();

        // Last breakpoint above the first: far clamp must win over near
        bp_set = '{10'd10, 10'd5, 10'd3, 10'd2, 10'd1, 10'd1, 10'd1, 10'd1000};
        dist_set = '{8'd20, 8'd40, 8'h80, 8'd60, 8'd80, 8'd100, 8'd120, 8'h7f};
        load_table();
        readings_to_send.push_back(10'd500);
        readings_to_send.push_back(10'd1023);
        readings_to_send.push_back(10'd7);
        readings_to_send.push_back(10'd0);
        settle();

        send_idle_pct = 19;
        recv_idle_pct = 60;
        make_table(1'b1);
        load_table();
        queue_readings(PHASE_ITEMS);
        settle();
        make_table(1'b0);
        load_table();
        queue_readings(PHASE_ITEMS);
        settle();

        send_idle_pct = 60;
        recv_idle_pct = 19;
        // Steepest slopes across the whole reading range
        make_table(1'b1);
        bp_set[0] = '1;
        bp_set[NPTS - 1] = '0;
        foreach (dist_set[i])
            dist_set[i] = (i % 2 == 0) ? 8'h80 : 8'h7f;
        load_table();
        queue_readings(PHASE_ITEMS);
        settle();
        make_table(1'b1);
        load_table();
        queue_readings(PHASE_ITEMS);
        settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        make_table(1'b1);
        load_table();
        mark = readings_sent + 40;
        queue_readings(PHASE_ITEMS);
        while (readings_sent < mark)
            @(negedge clk);
        // Hold the output long enough for the block to fill and stall its input
        long_stalls_asked++;
        settle();
        make_table(1'b1);
        load_table();
        queue_readings(PHASE_ITEMS);
        settle();

        if (distances_in_flight.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d results never arrived", $time, distances_in_flight.size());
        end
        $display("Converted %0d readings over %0d calibration tables: %0d near, %0d far,",
                 readings_sent, tables_loaded, near_count, far_count);
        $display("%0d interpolated; %0d results checked, %0d mismatches.",
                 interp_count, results_checked, mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
